// ----- rtl/thq_pkg.sv -----
// Shared types and constants for the terrain height query block.
// Used by every module under rtl/; depends on nothing.
package thq_pkg;

    localparam int COORD_W  = 11;   // grid coordinate width, covers any grid side up to 1024
    localparam int HEIGHT_W = 24;   // signed Q15.8 height
    localparam int POS_W    = 20;   // signed Q11.8 world position
    localparam int LOW_W    = 9;    // position bits below 512 LSB (one fifth of a cell)
    localparam int OFS_W    = 12;   // in-cell offset, 0 to 2559
    localparam int DIFF_W   = HEIGHT_W + 1;
    localparam int PROD_W   = 38;   // plane numerator width
    localparam int MAG_W    = 26;   // numerator magnitude over 512

    // One cell is 2560 LSB of position; 2560 = 512 * 5.
    localparam logic [OFS_W-1:0] CELL_Q8 = 12'd2560;
    localparam logic [OFS_W:0]   CELL_Q8_SUM = 13'd2560;

    // Floor division by 5 of a biased value: bias 1025 = 205 * 5 keeps it positive.
    localparam logic [11:0] DIV5_BIAS      = 12'd1025;
    localparam logic [12:0] RECIP5_NARROW  = 13'd6554;   // ceil(2^15 / 5)
    localparam int          RECIP5_NARROW_SH = 15;
    localparam logic [9:0]  CELL_BIAS      = 10'd195;    // 205 minus the 10-cell origin
    localparam logic [26:0] RECIP5_WIDE    = 27'd107374183;  // ceil(2^29 / 5)
    localparam int          RECIP5_WIDE_SH = 29;

    localparam int FIFO_AW    = 4;
    localparam int FIFO_DEPTH = 1 << FIFO_AW;

    // Located item: a grid write or a query cell with its in-cell offsets.
    typedef struct packed {
        logic                       valid;
        logic                       query;
        logic                       skip;     // query out of range, or write outside grid
        logic [OFS_W-1:0]           u;
        logic [OFS_W-1:0]           w;
        logic [COORD_W-1:0]         gx;
        logic [COORD_W-1:0]         gz;
        logic signed [HEIGHT_W-1:0] height;
    } cell_t;

    // Query with its four corner heights.
    typedef struct packed {
        logic                       valid;
        logic                       oor;
        logic [OFS_W-1:0]           u;
        logic [OFS_W-1:0]           w;
        logic signed [HEIGHT_W-1:0] h0;   // (gx,   gz)
        logic signed [HEIGHT_W-1:0] h1;   // (gx+1, gz)
        logic signed [HEIGHT_W-1:0] h2;   // (gx,   gz+1)
        logic signed [HEIGHT_W-1:0] h3;   // (gx+1, gz+1)
    } corner_t;

    typedef struct packed {
        logic                       valid;
        logic                       oor;
        logic signed [HEIGHT_W-1:0] height;
    } result_t;

endpackage

// ----- rtl/thq_locate.sv -----
// Cell location pipeline: floor division of the query position by the cell size.
// Three register stages; depends on thq_pkg.
module thq_locate #(
    parameter int GRID_SIDE = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 mode,
    input  logic [5:0]                           grid_x,
    input  logic [5:0]                           grid_z,
    input  logic signed [thq_pkg::HEIGHT_W-1:0]  height_in,
    input  logic signed [thq_pkg::POS_W-1:0]     pos_x,
    input  logic signed [thq_pkg::POS_W-1:0]     pos_z,
    output thq_pkg::cell_t                       loc
);

    localparam logic signed [11:0] CELL_MAX = 12'(GRID_SIDE - 2);
    localparam logic [thq_pkg::COORD_W-1:0] SIDE_C = thq_pkg::COORD_W'(GRID_SIDE);

    // Stage 1: floor by 512, bias for the divide by 5
    logic signed [thq_pkg::POS_W:0] nz;
    logic [11:0] ax_next;
    logic [11:0] az_next;

    assign nz      = -$signed({pos_z[thq_pkg::POS_W-1], pos_z});
    assign ax_next = {pos_x[thq_pkg::POS_W-1], pos_x[thq_pkg::POS_W-1:thq_pkg::LOW_W]}
                     + thq_pkg::DIV5_BIAS;
    assign az_next = nz[thq_pkg::POS_W:thq_pkg::LOW_W] + thq_pkg::DIV5_BIAS;

    logic                               s1_valid_reg;
    logic                               s1_query_reg;
    logic [11:0]                        s1_ax_reg;
    logic [11:0]                        s1_az_reg;
    logic [thq_pkg::LOW_W-1:0]          s1_lx_reg;
    logic [thq_pkg::LOW_W-1:0]          s1_lz_reg;
    logic [5:0]                         s1_wx_reg;
    logic [5:0]                         s1_wz_reg;
    logic signed [thq_pkg::HEIGHT_W-1:0] s1_h_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_query_reg <= mode;
        s1_ax_reg    <= ax_next;
        s1_az_reg    <= az_next;
        s1_lx_reg    <= pos_x[thq_pkg::LOW_W-1:0];
        s1_lz_reg    <= nz[thq_pkg::LOW_W-1:0];
        s1_wx_reg    <= grid_x;
        s1_wz_reg    <= grid_z;
        s1_h_reg     <= height_in;
    end

    // Stage 2: quotient by 5 through a reciprocal multiply
    logic [24:0] prod_x;
    logic [24:0] prod_z;

    assign prod_x = 25'(s1_ax_reg) * 25'(thq_pkg::RECIP5_NARROW);
    assign prod_z = 25'(s1_az_reg) * 25'(thq_pkg::RECIP5_NARROW);

    logic                               s2_valid_reg;
    logic                               s2_query_reg;
    logic [9:0]                         s2_qx_reg;
    logic [9:0]                         s2_qz_reg;
    logic [11:0]                        s2_ax_reg;
    logic [11:0]                        s2_az_reg;
    logic [thq_pkg::LOW_W-1:0]          s2_lx_reg;
    logic [thq_pkg::LOW_W-1:0]          s2_lz_reg;
    logic [5:0]                         s2_wx_reg;
    logic [5:0]                         s2_wz_reg;
    logic signed [thq_pkg::HEIGHT_W-1:0] s2_h_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_query_reg <= s1_query_reg;
        s2_qx_reg    <= prod_x[24:thq_pkg::RECIP5_NARROW_SH];
        s2_qz_reg    <= prod_z[24:thq_pkg::RECIP5_NARROW_SH];
        s2_ax_reg    <= s1_ax_reg;
        s2_az_reg    <= s1_az_reg;
        s2_lx_reg    <= s1_lx_reg;
        s2_lz_reg    <= s1_lz_reg;
        s2_wx_reg    <= s1_wx_reg;
        s2_wz_reg    <= s1_wz_reg;
        s2_h_reg     <= s1_h_reg;
    end

    // Stage 3: remainder, cell index, range checks
    logic [11:0]        rx_full;
    logic [11:0]        rz_full;
    logic signed [11:0] gxs;
    logic signed [11:0] gzs;
    logic               q_oor;
    logic               wr_skip;
    thq_pkg::cell_t     cell_next;
    thq_pkg::cell_t     cell_reg;

    assign rx_full = s2_ax_reg - ({s2_qx_reg, 2'b00} + {2'b00, s2_qx_reg});
    assign rz_full = s2_az_reg - ({s2_qz_reg, 2'b00} + {2'b00, s2_qz_reg});
    assign gxs     = $signed({2'b00, s2_qx_reg}) - $signed({2'b00, thq_pkg::CELL_BIAS});
    assign gzs     = $signed({2'b00, s2_qz_reg}) - $signed({2'b00, thq_pkg::CELL_BIAS});
    assign q_oor   = (gxs < 12'sd0) || (gxs > CELL_MAX) || (gzs < 12'sd0) || (gzs > CELL_MAX);
    assign wr_skip = ({5'b00000, s2_wx_reg} >= SIDE_C) || ({5'b00000, s2_wz_reg} >= SIDE_C);

    always_comb
    begin
        cell_next.valid  = s2_valid_reg;
        cell_next.query  = s2_query_reg;
        cell_next.skip   = s2_query_reg ? q_oor : wr_skip;
        cell_next.u      = {rx_full[2:0], s2_lx_reg};
        cell_next.w      = {rz_full[2:0], s2_lz_reg};
        cell_next.gx     = s2_query_reg ? gxs[thq_pkg::COORD_W-1:0] : {5'b00000, s2_wx_reg};
        cell_next.gz     = s2_query_reg ? gzs[thq_pkg::COORD_W-1:0] : {5'b00000, s2_wz_reg};
        cell_next.height = s2_h_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= '0;
        end
        else
        begin
            cell_reg <= cell_next;
        end
    end

    assign loc = cell_reg;

endmodule

// ----- rtl/thq_store.sv -----
// Height grid held in four parity banks, one per (x, z) parity pair, so the
// four corners of a cell are read in the same cycle. Depends on thq_pkg.
module thq_store #(
    parameter int GRID_SIDE = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  thq_pkg::cell_t    loc,
    output thq_pkg::corner_t  corner
);

    localparam int HB    = $clog2((GRID_SIDE + 1) / 2);
    localparam int AW    = 2 * HB;
    localparam int DEPTH = 1 << AW;

    // bank index = {x parity, z parity}
    genvar b;
    generate
        for (b = 0; b < 4; b++)
        begin : g_bank
            localparam logic BX = (b >= 2);
            localparam logic BZ = ((b % 2) == 1);

            logic [thq_pkg::COORD_W-1:0] x;
            logic [thq_pkg::COORD_W-1:0] z;
            logic [AW-1:0]               addr;
            logic                        we;
            logic [thq_pkg::HEIGHT_W-1:0] mem [DEPTH];
            logic [thq_pkg::HEIGHT_W-1:0] rd_reg;

            // step to the neighbor column or row that has this bank's parity
            assign x    = loc.gx + thq_pkg::COORD_W'(BX ^ loc.gx[0]);
            assign z    = loc.gz + thq_pkg::COORD_W'(BZ ^ loc.gz[0]);
            assign addr = {x[HB:1], z[HB:1]};
            assign we   = loc.valid && !loc.query && !loc.skip
                          && (loc.gx[0] == BX) && (loc.gz[0] == BZ);

            always_ff @(posedge clk)
            begin
                if (we)
                begin
                    mem[addr] <= loc.height;
                end
                rd_reg <= mem[addr];
            end
        end
    endgenerate

    logic                      side_valid_reg;
    logic                      side_oor_reg;
    logic [thq_pkg::OFS_W-1:0] side_u_reg;
    logic [thq_pkg::OFS_W-1:0] side_w_reg;
    logic                      side_px_reg;
    logic                      side_pz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_valid_reg <= 1'b0;
        end
        else
        begin
            side_valid_reg <= loc.valid && loc.query;
        end
    end

    always_ff @(posedge clk)
    begin
        side_oor_reg <= loc.skip;
        side_u_reg   <= loc.u;
        side_w_reg   <= loc.w;
        side_px_reg  <= loc.gx[0];
        side_pz_reg  <= loc.gz[0];
    end

    // route bank outputs to corners by the cell's parity
    logic [thq_pkg::HEIGHT_W-1:0] lo_a;
    logic [thq_pkg::HEIGHT_W-1:0] lo_b;
    logic [thq_pkg::HEIGHT_W-1:0] hi_a;
    logic [thq_pkg::HEIGHT_W-1:0] hi_b;

    assign lo_a = side_px_reg ? g_bank[2].rd_reg : g_bank[0].rd_reg;
    assign lo_b = side_px_reg ? g_bank[0].rd_reg : g_bank[2].rd_reg;
    assign hi_a = side_px_reg ? g_bank[3].rd_reg : g_bank[1].rd_reg;
    assign hi_b = side_px_reg ? g_bank[1].rd_reg : g_bank[3].rd_reg;

    always_comb
    begin
        corner.valid = side_valid_reg;
        corner.oor   = side_oor_reg;
        corner.u     = side_u_reg;
        corner.w     = side_w_reg;
        corner.h0    = $signed(side_pz_reg ? hi_a : lo_a);
        corner.h1    = $signed(side_pz_reg ? hi_b : lo_b);
        corner.h2    = $signed(side_pz_reg ? lo_a : hi_a);
        corner.h3    = $signed(side_pz_reg ? lo_b : hi_b);
    end

endmodule

// ----- rtl/thq_interp.sv -----
// Plane interpolation pipeline: triangle pick, two products, numerator sum and
// truncating divide by the cell size. Five register stages; depends on thq_pkg.
module thq_interp (
    input  logic               clk,
    input  logic               rst_n,
    input  thq_pkg::corner_t   corner,
    output thq_pkg::result_t   result
);

    // Stage 4: pick the triangle and its edge operands
    logic [thq_pkg::OFS_W:0]             uw_sum;
    logic                                upper;
    logic signed [thq_pkg::DIFF_W-1:0]   h0e, h1e, h2e, h3e;

    assign uw_sum = {1'b0, corner.u} + {1'b0, corner.w};
    assign upper  = uw_sum >= thq_pkg::CELL_Q8_SUM;
    assign h0e    = thq_pkg::DIFF_W'(corner.h0);
    assign h1e    = thq_pkg::DIFF_W'(corner.h1);
    assign h2e    = thq_pkg::DIFF_W'(corner.h2);
    assign h3e    = thq_pkg::DIFF_W'(corner.h3);

    logic                                s4_valid_reg;
    logic                                s4_oor_reg;
    logic signed [thq_pkg::HEIGHT_W-1:0] s4_base_reg;
    logic signed [thq_pkg::DIFF_W-1:0]   s4_d1_reg;
    logic signed [thq_pkg::DIFF_W-1:0]   s4_d2_reg;
    logic [thq_pkg::OFS_W-1:0]           s4_c1_reg;
    logic [thq_pkg::OFS_W-1:0]           s4_c2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s4_valid_reg <= corner.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s4_oor_reg <= corner.oor;
        if (upper)
        begin
            s4_base_reg <= corner.h3;
            s4_d1_reg   <= h2e - h3e;
            s4_c1_reg   <= thq_pkg::CELL_Q8 - corner.u;
            s4_d2_reg   <= h1e - h3e;
            s4_c2_reg   <= thq_pkg::CELL_Q8 - corner.w;
        end
        else
        begin
            s4_base_reg <= corner.h0;
            s4_d1_reg   <= h1e - h0e;
            s4_c1_reg   <= corner.u;
            s4_d2_reg   <= h2e - h0e;
            s4_c2_reg   <= corner.w;
        end
    end

    // Stage 5: edge products
    logic signed [thq_pkg::PROD_W-1:0] p1_next;
    logic signed [thq_pkg::PROD_W-1:0] p2_next;

    assign p1_next = thq_pkg::PROD_W'(s4_d1_reg) * thq_pkg::PROD_W'($signed({1'b0, s4_c1_reg}));
    assign p2_next = thq_pkg::PROD_W'(s4_d2_reg) * thq_pkg::PROD_W'($signed({1'b0, s4_c2_reg}));

    logic                                s5_valid_reg;
    logic                                s5_oor_reg;
    logic signed [thq_pkg::HEIGHT_W-1:0] s5_base_reg;
    logic signed [thq_pkg::PROD_W-1:0]   s5_p1_reg;
    logic signed [thq_pkg::PROD_W-1:0]   s5_p2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s5_oor_reg  <= s4_oor_reg;
        s5_base_reg <= s4_base_reg;
        s5_p1_reg   <= p1_next;
        s5_p2_reg   <= p2_next;
    end

    // Stage 6: numerator = base * 2560 + both products
    logic signed [thq_pkg::PROD_W-1:0] base_ext;
    logic signed [thq_pkg::PROD_W-1:0] num_next;

    assign base_ext = thq_pkg::PROD_W'(s5_base_reg);
    assign num_next = (base_ext <<< 11) + (base_ext <<< 9) + s5_p1_reg + s5_p2_reg;

    logic                              s6_valid_reg;
    logic                              s6_oor_reg;
    logic signed [thq_pkg::PROD_W-1:0] s6_num_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_valid_reg <= 1'b0;
        end
        else
        begin
            s6_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s6_oor_reg <= s5_oor_reg;
        s6_num_reg <= num_next;
    end

    // Stage 7: magnitude, drop the factor of 512
    logic [thq_pkg::PROD_W-1:0] mag;

    assign mag = s6_num_reg[thq_pkg::PROD_W-1] ? thq_pkg::PROD_W'(-s6_num_reg)
                                               : thq_pkg::PROD_W'(s6_num_reg);

    logic                       s7_valid_reg;
    logic                       s7_oor_reg;
    logic                       s7_neg_reg;
    logic [thq_pkg::MAG_W-1:0]  s7_mag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s7_valid_reg <= 1'b0;
        end
        else
        begin
            s7_valid_reg <= s6_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s7_oor_reg <= s6_oor_reg;
        s7_neg_reg <= s6_num_reg[thq_pkg::PROD_W-1];
        s7_mag_reg <= mag[thq_pkg::MAG_W+8:9];
    end

    // Stage 8: divide the magnitude by 5 through a reciprocal multiply
    logic [52:0] quot_prod;

    assign quot_prod = 53'(s7_mag_reg) * 53'(thq_pkg::RECIP5_WIDE);

    logic                           s8_valid_reg;
    logic                           s8_oor_reg;
    logic                           s8_neg_reg;
    logic [thq_pkg::HEIGHT_W-1:0]   s8_q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s8_valid_reg <= 1'b0;
        end
        else
        begin
            s8_valid_reg <= s7_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s8_oor_reg <= s7_oor_reg;
        s8_neg_reg <= s7_neg_reg;
        s8_q_reg   <= quot_prod[thq_pkg::RECIP5_WIDE_SH +: thq_pkg::HEIGHT_W];
    end

    // restore the sign: truncation toward zero; an out-of-range query gives height 0
    always_comb
    begin
        result.valid = s8_valid_reg;
        result.oor   = s8_oor_reg;
        if (s8_oor_reg)
        begin
            result.height = '0;
        end
        else if (s8_neg_reg)
        begin
            result.height = $signed(-s8_q_reg);
        end
        else
        begin
            result.height = $signed(s8_q_reg);
        end
    end

endmodule

// ----- rtl/thq_out_fifo.sv -----
// Result queue with a credit count that covers queries still in the pipeline,
// so the pipeline itself never stalls. Depends on thq_pkg.
module thq_out_fifo (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  thq_pkg::result_t                     push,
    input  logic                                 claim,
    output logic                                 room,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [thq_pkg::HEIGHT_W-1:0]  out_height,
    output logic                                 out_oor
);

    localparam int ENTRY_W = thq_pkg::HEIGHT_W + 1;

    logic [ENTRY_W-1:0]          fifo_mem [thq_pkg::FIFO_DEPTH];
    logic [thq_pkg::FIFO_AW-1:0] wr_ptr_reg;
    logic [thq_pkg::FIFO_AW-1:0] rd_ptr_reg;
    logic [thq_pkg::FIFO_AW:0]   count_reg;
    logic [thq_pkg::FIFO_AW:0]   count_next;
    logic [thq_pkg::FIFO_AW:0]   credit_reg;
    logic [thq_pkg::FIFO_AW:0]   credit_next;
    logic                        pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = count_reg != '0;
    assign room      = credit_reg < (thq_pkg::FIFO_AW + 1)'(thq_pkg::FIFO_DEPTH);

    // credit counts accepted queries not yet handed out
    assign credit_next = credit_reg + (thq_pkg::FIFO_AW + 1)'(claim)
                         - (thq_pkg::FIFO_AW + 1)'(pop);
    assign count_next  = count_reg + (thq_pkg::FIFO_AW + 1)'(push.valid)
                         - (thq_pkg::FIFO_AW + 1)'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            credit_reg <= '0;
        end
        else
        begin
            if (push.valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg  <= count_next;
            credit_reg <= credit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            fifo_mem[wr_ptr_reg] <= {push.oor, push.height};
        end
    end

    assign out_height = $signed(fifo_mem[rd_ptr_reg][thq_pkg::HEIGHT_W-1:0]);
    assign out_oor    = fifo_mem[rd_ptr_reg][thq_pkg::HEIGHT_W];

endmodule

// ----- rtl/terrain_height_query_top.sv -----
// Terrain height query, top level: stream ports, cell locate, banked height
// store, plane interpolation and result queue. Depends on thq_pkg and all thq_ modules.
//
// One item is taken per clock: a write (tuser 0) stores one Q15.8 height at a grid
// vertex, a query (tuser 1) returns the Q15.8 height of the terrain triangle under a
// Q11.8 world position, with out_of_range set and height 0 when the cell is off the
// grid. Writes outside the grid are dropped and return nothing. The grid lives in four
// single-port banks split by the parity of the vertex coordinates, so the four corners
// of a cell are read in the same cycle and the sustained rate is one item per clock.
// A query result passes the locate, bank read and interpolation registers and the result
// queue; results leave in order. s_axis_tready drops only while 16 accepted queries are
// still in flight or waiting to be taken. A write is seen by every query accepted after
// it. The store has no clearing pass: a vertex reads undefined until it has been written.
module terrain_height_query_top #(
    parameter int GRID_SIDE = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // grid_x[5:0], grid_z[11:6], height_in[35:12], pos_x[55:36], pos_z[75:56], zero[79:76]
    input  logic [79:0] s_axis_tdata,
    // mode[0]
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // height_out[23:0]
    output logic [23:0] m_axis_tdata,
    // out_of_range[0]
    output logic        m_axis_tuser
);

    logic               in_xfer;
    logic               room;
    thq_pkg::cell_t     loc;
    thq_pkg::corner_t   corner;
    thq_pkg::result_t   result;
    logic signed [thq_pkg::HEIGHT_W-1:0] out_height;

    assign s_axis_tready = room;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    thq_locate #(
        .GRID_SIDE (GRID_SIDE)
    ) u_locate (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_xfer),
        .mode      (s_axis_tuser),
        .grid_x    (s_axis_tdata[5:0]),
        .grid_z    (s_axis_tdata[11:6]),
        .height_in ($signed(s_axis_tdata[35:12])),
        .pos_x     ($signed(s_axis_tdata[55:36])),
        .pos_z     ($signed(s_axis_tdata[75:56])),
        .loc       (loc)
    );

    thq_store #(
        .GRID_SIDE (GRID_SIDE)
    ) u_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .loc    (loc),
        .corner (corner)
    );

    thq_interp u_interp (
        .clk    (clk),
        .rst_n  (rst_n),
        .corner (corner),
        .result (result)
    );

    thq_out_fifo u_out_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (result),
        .claim      (in_xfer && s_axis_tuser),
        .room       (room),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_height (out_height),
        .out_oor    (m_axis_tuser)
    );

    assign m_axis_tdata = out_height;

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for terrain_height_query_top: a directed table, then random
// writes and queries, checked against a built-in plane-height predictor or a typed row's own result.
// Depends on thq_pkg and the RTL under rtl/.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HEIGHT_W     = thq_pkg::HEIGHT_W;
    localparam int POS_W        = thq_pkg::POS_W;
    localparam int GRID_SIDE    = 64;
    localparam int CELL_LSB     = 2560;
    localparam int ORIGIN_CELLS = 10;
    localparam int RANDOM_ITEMS = 650;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 20;
    localparam int N_DIRECTED   = 23;

    typedef enum bit {OP_WRITE = 1'b0, OP_QUERY = 1'b1} op_t;

    typedef struct packed {
        op_t                      op;
        logic [5:0]               gx;
        logic [5:0]               gz;
        logic signed [HEIGHT_W-1:0] height;
        logic signed [POS_W-1:0]  px;
        logic signed [POS_W-1:0]  pz;
    } terrain_item_t;

    typedef struct packed {
        logic signed [HEIGHT_W-1:0] height;
        logic                     oor;
    } height_result_t;

    typedef struct packed {
        terrain_item_t  item;
        bit             typed;
        height_result_t res;
    } directed_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tuser;

    logic signed [HEIGHT_W-1:0] grid_heights [GRID_SIDE][GRID_SIDE];
    bit                         grid_written [GRID_SIDE][GRID_SIDE];
    height_result_t             pending_heights [$];

    int send_idle_pct = 25;
    int recv_idle_pct = 70;
    int items_sent = 0;
    int mismatches = 0;
    int stall_cycles = 0;

    // Cell (0,0) spans x in [-25600, -23040), world z in (23040, 25600].
    directed_row_t directed_rows [N_DIRECTED] = '{
        '{'{OP_WRITE, 6'd0,  6'd0,  24'h7FFFFF, 20'sd0, 20'sd0},      1'b0, '{24'sd0, 1'b0}},
        '{'{OP_WRITE, 6'd1,  6'd0,  24'h800000, 20'sd0, 20'sd0},      1'b0, '{24'sd0, 1'b0}},
        '{'{OP_WRITE, 6'd0,  6'd1,  24'sd0,     20'sd0, 20'sd0},      1'b0, '{24'sd0, 1'b0}},
        '{'{OP_WRITE, 6'd1,  6'd1,  24'sd1234,  20'sd0, 20'sd0},      1'b0, '{24'sd0, 1'b0}},
        '{'{OP_QUERY, 6'h3F, 6'h3F, 24'hFFFFFF, -20'sd25600, 20'sd25600},
            1'b1, '{24'h7FFFFF, 1'b0}},
        '{'{OP_QUERY, 6'd0,  6'd0,  24'sd0, -20'sd23041, 20'sd25600}, 1'b0, '{24'sd0, 1'b0}},
        '{'{OP_QUERY, 6'd0,  6'd0,  24'sd0, -20'sd25600, 20'sd23041}, 1'b0, '{24'sd0, 1'b0}},
        '{'{OP_QUERY, 6'd0,  6'd0,  24'sd0, -20'sd24320, 20'sd24320}, 1'b0, '{24'sd0, 1'b0}},
        '{'{OP_QUERY, 6'd0,  6'd0,  24'sd0, -20'sd24321, 20'sd24320}, 1'b0, '{24'sd0, 1'b0}},
        '{'{OP_QUERY, 6'd0,  6'd0,  24'sd0, -20'sd23041, 20'sd23041}, 1'b0, '{24'sd0, 1'b0}},
        '{'{OP_WRITE, 6'd0,  6'd0,  24'h800000, 20'sh7FFFF, 20'sh80000}, 1'b0, '{24'sd0, 1'b0}},
        '{'{OP_QUERY, 6'd0,  6'd0,  24'sd0, -20'sd25600, 20'sd25600},
            1'b1, '{24'h800000, 1'b0}},
        '{'{OP_WRITE, 6'd62, 6'd62, 24'hFFFFFF, 20'sd0, 20'sd0},      1'b0, '{24'sd0, 1'b0}},
        '{'{OP_WRITE, 6'd63, 6'd62, 24'h7FFFFF, 20'sd0, 20'sd0},      1'b0, '{24'sd0, 1'b0}},
        '{'{OP_WRITE, 6'd62, 6'd63, 24'h800000, 20'sd0, 20'sd0},      1'b0, '{24'sd0, 1'b0}},
        '{'{OP_WRITE, 6'h3F, 6'h3F, 24'h555555, 20'sd0, 20'sd0},      1'b0, '{24'sd0, 1'b0}},
        '{'{OP_QUERY, 6'd0,  6'd0,  24'sd0, 20'sd135679, -20'sd135679}, 1'b0, '{24'sd0, 1'b0}},
        // after the last column and row: one step past each edge, and the position extremes
        '{'{OP_QUERY, 6'd0,  6'd0,  24'sd0, 20'sd135680, -20'sd135679}, 1'b1, '{24'sd0, 1'b1}},
        '{'{OP_QUERY, 6'd0,  6'd0,  24'sd0, -20'sd25601, 20'sd25600},   1'b1, '{24'sd0, 1'b1}},
        '{'{OP_QUERY, 6'd0,  6'd0,  24'sd0, -20'sd25600, 20'sd25601},   1'b1, '{24'sd0, 1'b1}},
        '{'{OP_QUERY, 6'd0,  6'd0,  24'sd0, -20'sd25600, -20'sd135680}, 1'b1, '{24'sd0, 1'b1}},
        '{'{OP_QUERY, 6'd0,  6'd0,  24'sd0, 20'sh7FFFF, 20'sh80000},    1'b1, '{24'sd0, 1'b1}},
        '{'{OP_QUERY, 6'd0,  6'd0,  24'sd0, 20'sh80000, 20'sh7FFFF},    1'b1, '{24'sd0, 1'b1}}
    };

    terrain_height_query_top #(
        .GRID_SIDE(GRID_SIDE)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Floor division of a Q11.8 coordinate by the cell size, shifted by the grid origin.
    function automatic longint cell_of(input longint pos);
        longint q;
        q = pos / CELL_LSB;
        if ((pos % CELL_LSB) != 0 && pos < 0)
            q = q - 1;
        return q + ORIGIN_CELLS;
    endfunction

    function automatic height_result_t terrain_height_at(input logic signed [POS_W-1:0] px_in,
                                                          input logic signed [POS_W-1:0] pz_in);
        height_result_t res;
        longint px, nz, gx, gz, u, w, h0, h1, h2, h3, num;
        px = px_in;
        nz = -longint'(pz_in);
        gx = cell_of(px);
        gz = cell_of(nz);
        res.height = '0;
        res.oor    = 1'b1;
        if (gx < 0 || gx > GRID_SIDE - 2 || gz < 0 || gz > GRID_SIDE - 2)
            return res;
        u  = px - (gx - ORIGIN_CELLS) * CELL_LSB;
        w  = nz - (gz - ORIGIN_CELLS) * CELL_LSB;
        h0 = grid_heights[gx][gz];
        h1 = grid_heights[gx + 1][gz];
        h2 = grid_heights[gx][gz + 1];
        h3 = grid_heights[gx + 1][gz + 1];
        // Split along the (gx+1,gz)-(gx,gz+1) diagonal; the diagonal goes to the far triangle.
        if (u + w < CELL_LSB)
            num = h0 * CELL_LSB + (h1 - h0) * u + (h2 - h0) * w;
        else
            num = h3 * CELL_LSB + (h2 - h3) * (CELL_LSB - u) + (h1 - h3) * (CELL_LSB - w);
        res.height = HEIGHT_W'(num / CELL_LSB);
        res.oor    = 1'b0;
        return res;
    endfunction

    // Append one expected result at the tail of the queue.
    function automatic void queue_result(input height_result_t r);
        pending_heights.insert(pending_heights.size(), r);
    endfunction

    // Drive one transaction and hold it until accepted; call right after a rising edge.
    task automatic issue(input terrain_item_t it, input bit typed, input height_result_t typed_res);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.op;
        s_axis_tdata  <= {4'b0, it.pz, it.px, it.height, it.gz, it.gx};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
        if (it.op == OP_WRITE)
        begin
            grid_heights[it.gx][it.gz] = it.height;
            grid_written[it.gx][it.gz] = 1'b1;
        end
        else
            queue_result(typed ? typed_res : terrain_height_at(it.px, it.pz));
    endtask

    function automatic logic signed [HEIGHT_W-1:0] random_height();
        case ($urandom_range(9))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'sd0;
            default: return HEIGHT_W'($urandom);
        endcase
    endfunction

    function automatic terrain_item_t random_item(input op_t op);
        terrain_item_t it;
        it.op     = op;
        it.gx     = 6'($urandom);
        it.gz     = 6'($urandom);
        it.height = random_height();
        it.px     = POS_W'($urandom);
        it.pz     = POS_W'($urandom);
        return it;
    endfunction

    // Load any corner of the cell not yet written so the query never reads an empty vertex.
    task automatic fill_cell_corners(input int gx, input int gz);
        terrain_item_t it;
        for (int dx = 0; dx < 2; dx++)
        begin
            for (int dz = 0; dz < 2; dz++)
            begin
                if (!grid_written[gx + dx][gz + dz])
                begin
                    it    = random_item(OP_WRITE);
                    it.gx = 6'(gx + dx);
                    it.gz = 6'(gz + dz);
                    issue(it, 1'b0, '0);
                end
            end
        end
    endtask

    task automatic random_traffic();
        terrain_item_t it;
        int            pick, gx, gz, u, w;
        longint        cx, cz;
        pick = $urandom_range(99);
        if (pick < 35)
            issue(random_item(OP_WRITE), 1'b0, '0);
        else if (pick < 85)
        begin
            // Mostly a small patch so the grid fills quickly, sometimes anywhere.
            if ($urandom_range(99) < 60)
            begin
                gx = 20 + $urandom_range(7);
                gz = 20 + $urandom_range(7);
            end
            else
            begin
                gx = $urandom_range(GRID_SIDE - 2);
                gz = $urandom_range(GRID_SIDE - 2);
            end
            case ($urandom_range(7))
                0: u = 0;
                1: u = CELL_LSB - 1;
                default: u = $urandom_range(CELL_LSB - 1);
            endcase
            case ($urandom_range(7))
                0: w = CELL_LSB - 1 - u;
                1: w = (u == 0) ? 0 : CELL_LSB - u;
                default: w = $urandom_range(CELL_LSB - 1);
            endcase
            fill_cell_corners(gx, gz);
            it    = random_item(OP_QUERY);
            it.px = POS_W'((gx - ORIGIN_CELLS) * CELL_LSB + u);
            it.pz = POS_W'(-((gz - ORIGIN_CELLS) * CELL_LSB + w));
            issue(it, 1'b0, '0);
        end
        else
        begin
            it = random_item(OP_QUERY);
            cx = cell_of(longint'(it.px));
            cz = cell_of(-longint'(it.pz));
            if (cx >= 0 && cx <= GRID_SIDE - 2 && cz >= 0 && cz <= GRID_SIDE - 2)
                fill_cell_corners(int'(cx), int'(cz));
            issue(it, 1'b0, '0);
        end
    endtask

    always @(posedge clk)
    begin : check_results
        height_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_heights.size() == 0)
            begin
                $display("%0t: unexpected result: height %0d out_of_range %0b",
                         $time, $signed(m_axis_tdata), m_axis_tuser);
                mismatches++;
            end
            else
            begin
                want = pending_heights.pop_front();
                if (want.height !== m_axis_tdata)
                begin
                    $display("%0t: height_out mismatch: expected %0d, actual %0d",
                             $time, want.height, $signed(m_axis_tdata));
                    mismatches++;
                end
                if (want.oor !== m_axis_tuser)
                begin
                    $display("%0t: out_of_range mismatch: expected %0b, actual %0b",
                             $time, want.oor, m_axis_tuser);
                    mismatches++;
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Abort when no transaction moves on either side for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin : stimulus
        int random_start;
        bit paused;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
            issue(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].res);

        random_start = items_sent;
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 25;
                    recv_idle_pct = 70;
                end
                1:
                begin
                    send_idle_pct = 70;
                    recv_idle_pct = 25;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            paused = 1'b0;
            while (items_sent - random_start < (phase + 1) * RANDOM_ITEMS / 3)
            begin
                random_traffic();
                // Hold off the sender once per phase until the pipeline has drained.
                if (!paused && items_sent - random_start >= phase * RANDOM_ITEMS / 3 + 100)
                begin
                    paused = 1'b1;
                    s_axis_tvalid <= 1'b0;
                    @(posedge clk);
                    while (pending_heights.size() != 0)
                        @(posedge clk);
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_heights.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- terrain_height_query_top.f -----
rtl/thq_pkg.sv
rtl/thq_locate.sv
rtl/thq_store.sv
rtl/thq_interp.sv
rtl/thq_out_fifo.sv
rtl/terrain_height_query_top.sv
tb/testbench.sv
